// File: hdl/swmax_pkg.sv
// Package for the sliding window maximum block.
// Shared constants and the pipeline tag type; no dependencies.
package swmax_pkg;

    localparam int WINDOW_MAX_DEF  = 64;
    localparam int SAMPLE_BITS_DEF = 32;
    localparam int CFG_BITS        = 7;
    localparam int OUT_BITS        = 32;
    localparam int GROUP_CELLS     = 8;

    localparam logic [CFG_BITS-1:0] WINDOW_RESET = 7'd4;

    typedef struct packed {
        logic produce;
        logic final_res;
    } t_tag;

endpackage

// File: hdl/sliding_window_maximum.sv
// Sliding window maximum, top level: cell chain, group selects, output stage.
// Depends on swmax_pkg, swmax_cell and swmax_group.
//
// Input channel: i_valid/o_stall carry i_sample and i_last; a word is taken
// at an edge with i_valid high and o_stall low. Output channel: o_valid/i_stall
// carry o_window_max and o_final_res.
// Configuration: i_cfg_we writes i_cfg_wdata to the window size (0 acts as 1,
// values above WINDOW_MAX act as WINDOW_MAX). Write only while idle.
// Each word shifts into cell 0 of a WINDOW_MAX cell chain; cell j holds the
// sample taken j words ago if it is still a candidate. The maximum is the
// oldest candidate inside the window, found by an 8-cell group select and a
// final select across groups.
// Throughput: one word per cycle while o_stall is low. A result passes the cell
// stage, the group stage and the output register in turn. Words that give no
// result (window not yet full) drain without using the output register.
// Reset clears the chain, counters and pipeline, and sets window size to 4.
// A word flagged last clears the sequence from the next word on.
// When i_stall holds, the output register, the group stage and the cell
// stage fill in turn; then o_stall rises until the output word is taken.
module sliding_window_maximum #(
    parameter int WINDOW_MAX  = swmax_pkg::WINDOW_MAX_DEF,
    parameter int SAMPLE_BITS = swmax_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic signed [SAMPLE_BITS-1:0]        i_sample,
    input  logic                                 i_last,
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic signed [swmax_pkg::OUT_BITS-1:0] o_window_max,
    output logic                                 o_final_res,
    input  logic                                 i_cfg_we,
    input  logic [swmax_pkg::CFG_BITS-1:0]       i_cfg_wdata
);

    localparam int GC = swmax_pkg::GROUP_CELLS;
    localparam int NG = (WINDOW_MAX + GC - 1) / GC;
    localparam int NP = NG * GC;
    localparam int KW = $clog2(WINDOW_MAX + 1);
    localparam int KX = (KW > swmax_pkg::CFG_BITS) ? KW : swmax_pkg::CFG_BITS;

    logic [swmax_pkg::CFG_BITS-1:0] r_window_size;
    logic                           r_flush;
    logic [KW-1:0]                  r_seen;
    logic [KW-1:0]                  n_seen;
    logic [KW-1:0]                  w_k;
    logic [KX-1:0]                  w_ws;
    logic [KW-1:0]                  w_base;

    logic                 r_c_valid;
    swmax_pkg::t_tag      r_c_tag;
    logic [KW-1:0]        r_c_k;
    logic                 r_g_valid;
    swmax_pkg::t_tag      r_g_tag;
    logic                 r_o_valid;
    logic                 r_o_final;
    logic [SAMPLE_BITS-1:0] r_o_value;
    logic                 n_o_valid;
    logic [SAMPLE_BITS-1:0] n_o_value;

    logic w_accept;
    logic w_grp_load;
    logic w_out_take;

    logic                          w_valid [WINDOW_MAX];
    logic signed [SAMPLE_BITS-1:0] w_value [WINDOW_MAX];
    logic [NP-1:0]                 w_qual;
    logic [NP-1:0][SAMPLE_BITS-1:0] w_qval;
    logic [NG-1:0]                 w_gfound;
    logic [SAMPLE_BITS-1:0]        w_gvalue [NG];
    logic                          w_any;

    // handshake
    always_comb begin
        w_out_take = r_g_valid && (!r_g_tag.produce || !r_o_valid || !i_stall);
        w_grp_load = r_c_valid && (!r_g_valid || w_out_take);
        o_stall    = r_c_valid && !w_grp_load;
        w_accept   = i_valid && !o_stall;
    end

    // effective window and fill count
    always_comb begin
        w_ws = KX'(r_window_size);
        if (w_ws == '0) begin
            w_k = KW'(1);
        end else if (w_ws > KX'(WINDOW_MAX)) begin
            w_k = KW'(WINDOW_MAX);
        end else begin
            w_k = KW'(w_ws);
        end
        w_base = r_flush ? '0 : r_seen;
        if (w_base > w_k) begin
            w_base = w_k;
        end
        n_seen = (w_base < w_k) ? w_base + KW'(1) : w_base;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_size <= swmax_pkg::WINDOW_RESET;
        end else if (i_cfg_we) begin
            r_window_size <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flush <= 1'b0;
            r_seen  <= '0;
        end else if (w_accept) begin
            r_flush <= i_last;
            r_seen  <= n_seen;
        end
    end

    // cell chain
    for (genvar j = 0; j < WINDOW_MAX; j++) begin : g_cell
        if (j == 0) begin : g_head
            swmax_cell #(
                .SAMPLE_BITS(SAMPLE_BITS)
            ) u_cell (
                .i_clk       (i_clk),
                .i_rst_n     (i_rst_n),
                .i_en        (w_accept),
                .i_flush     (r_flush),
                .i_drop_en   (1'b0),
                .i_sample    (i_sample),
                .i_prev_valid(1'b1),
                .i_prev_value(i_sample),
                .o_valid     (w_valid[j]),
                .o_value     (w_value[j])
            );
        end else begin : g_body
            swmax_cell #(
                .SAMPLE_BITS(SAMPLE_BITS)
            ) u_cell (
                .i_clk       (i_clk),
                .i_rst_n     (i_rst_n),
                .i_en        (w_accept),
                .i_flush     (r_flush),
                .i_drop_en   (1'b1),
                .i_sample    (i_sample),
                .i_prev_valid(w_valid[j-1]),
                .i_prev_value(w_value[j-1]),
                .o_valid     (w_valid[j]),
                .o_value     (w_value[j])
            );
        end
    end

    always_comb begin
        w_qual = '0;
        w_qval = '0;
        for (int j = 0; j < WINDOW_MAX; j++) begin
            w_qual[j] = w_valid[j] && (KW'(j) < r_c_k);
            w_qval[j] = w_value[j];
        end
    end

    // group selects
    for (genvar g = 0; g < NG; g++) begin : g_group
        swmax_group #(
            .SAMPLE_BITS(SAMPLE_BITS),
            .GROUP_CELLS(GC)
        ) u_group (
            .i_clk  (i_clk),
            .i_load (w_grp_load),
            .i_qual (w_qual[g*GC +: GC]),
            .i_value(w_qval[g*GC +: GC]),
            .o_found(w_gfound[g]),
            .o_value(w_gvalue[g])
        );
    end

    // pipeline control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
            r_g_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_c_valid <= w_accept || (r_c_valid && !w_grp_load);
            r_g_valid <= w_grp_load || (r_g_valid && !w_out_take);
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_c_tag.produce   <= (n_seen >= w_k);
            r_c_tag.final_res <= i_last;
            r_c_k             <= w_k;
        end
        if (w_grp_load) begin
            r_g_tag <= r_c_tag;
        end
        if (w_out_take && r_g_tag.produce) begin
            r_o_value <= n_o_value;
            r_o_final <= r_g_tag.final_res;
        end
    end

    // output select across groups
    always_comb begin
        n_o_valid = (r_o_valid && i_stall) || (w_out_take && r_g_tag.produce);
        n_o_value = w_gvalue[0];
        w_any     = 1'b0;
        for (int g = 0; g < NG; g++) begin
            if (w_gfound[g]) begin
                n_o_value = w_gvalue[g];
                w_any     = 1'b1;
            end
        end
    end

    assign o_valid     = r_o_valid;
    assign o_final_res = r_o_final;

    if (SAMPLE_BITS >= swmax_pkg::OUT_BITS) begin : g_out_trunc
        assign o_window_max = r_o_value[swmax_pkg::OUT_BITS-1:0];
    end else begin : g_out_ext
        assign o_window_max = {{(swmax_pkg::OUT_BITS - SAMPLE_BITS){1'b0}}, r_o_value};
    end

    // checks
    a_head_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> w_valid[0])
        else $error("newest cell not live after accept");

    a_max_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_g_valid && r_g_tag.produce) |-> w_any)
        else $error("no candidate in window for a result");

    a_seen_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_seen <= KW'(WINDOW_MAX))
        else $error("fill count out of range");

    a_flush_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_last) |=> r_flush)
        else $error("sequence end not recorded");

endmodule

// File: hdl/swmax_cell.sv
// One candidate cell: takes its neighbor's entry each word; if enabled, drops
// it on flush or if a newer sample is not smaller. Uses swmax_pkg defaults.
module swmax_cell #(
    parameter int SAMPLE_BITS = swmax_pkg::SAMPLE_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_flush,
    input  logic                          i_drop_en,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    input  logic                          i_prev_valid,
    input  logic signed [SAMPLE_BITS-1:0] i_prev_value,
    output logic                          o_valid,
    output logic signed [SAMPLE_BITS-1:0] o_value
);

    logic                          r_valid;
    logic signed [SAMPLE_BITS-1:0] r_value;
    logic                          n_valid;
    logic                          w_drop;

    always_comb begin
        w_drop  = i_drop_en && (i_flush || (i_prev_value <= i_sample));
        n_valid = i_prev_valid && !w_drop;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_value <= i_prev_value;
        end
    end

    assign o_valid = r_valid;
    assign o_value = r_value;

endmodule

// File: hdl/swmax_group.sv
// Registered oldest-candidate select over one group of cells.
// Uses swmax_pkg defaults.
module swmax_group #(
    parameter int SAMPLE_BITS = swmax_pkg::SAMPLE_BITS_DEF,
    parameter int GROUP_CELLS = swmax_pkg::GROUP_CELLS
) (
    input  logic                                   i_clk,
    input  logic                                   i_load,
    input  logic [GROUP_CELLS-1:0]                 i_qual,
    input  logic [GROUP_CELLS-1:0][SAMPLE_BITS-1:0] i_value,
    output logic                                   o_found,
    output logic [SAMPLE_BITS-1:0]                 o_value
);

    logic                   r_found;
    logic [SAMPLE_BITS-1:0] r_value;
    logic                   n_found;
    logic [SAMPLE_BITS-1:0] n_value;

    // highest qualifying index is the oldest live candidate
    always_comb begin
        n_found = 1'b0;
        n_value = i_value[0];
        for (int c = 0; c < GROUP_CELLS; c++) begin
            if (i_qual[c]) begin
                n_found = 1'b1;
                n_value = i_value[c];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_found <= n_found;
            r_value <= n_value;
        end
    end

    assign o_found = r_found;
    assign o_value = r_value;

endmodule
